[sv/tcce_pkg.sv]
// ----------------------------------------------------------------------------
// Text console cell engine package
// Operation codes, register indexes, character codes, cell words and the
// control structs shared between the core and the sweep sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcce_pkg;

  localparam int POS_W     = 11;
  localparam int CELL_W    = 16;
  localparam int ADDR_IN_W = 11;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_DELETE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_FULL_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK_CELL = 1'b1;

  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;

  // White space on black, used by clear and as the reset blank word.
  localparam logic [CELL_W-1:0] CLEAR_WORD  = 16'h0F20;
  localparam logic [CELL_W-1:0] BLANK_RESET = 16'h0F20;

  typedef struct packed {
    logic start;
    logic clear;
  } sweep_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sweep_sts_t;

endpackage

`default_nettype wire

[sv/tcce_if.sv]
// ----------------------------------------------------------------------------
// Text console cell engine channels
// Valid/ready channels for the request items and the result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcce_in_if;
  import tcce_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           operation;
  logic [7:0]           character;
  logic [7:0]           attribute;
  logic [ADDR_IN_W-1:0] cell_address;

  modport source (output valid, output operation, output character,
                  output attribute, output cell_address, input ready);
  modport sink   (input valid, input operation, input character,
                  input attribute, input cell_address, output ready);
endinterface

interface tcce_out_if;
  import tcce_pkg::*;

  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  cursor_position;
  logic [CELL_W-1:0] cell_data;

  modport source (output valid, output cursor_position, output cell_data,
                  input ready);
  modport sink   (input valid, input cursor_position, input cell_data,
                  output ready);
endinterface

`default_nettype wire

[sv/tcce_cell_mem.sv]
// ----------------------------------------------------------------------------
// Text console cell memory
// Simple dual-port cell store: one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_cell_mem #(
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = 11,
  parameter int DATA_W = 16
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata_r
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/tcce_sweep.sv]
// ----------------------------------------------------------------------------
// Text console sweep sequencer
// Walks the cell memory for scroll-up (copy each row from the one below, then
// fill the last row with the blank word) and for clear (fill every row).
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_sweep #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire tcce_pkg::sweep_req_t                   req,
  input  wire logic [$clog2(COLUMNS):0]               act_width,
  input  wire logic [tcce_pkg::CELL_W-1:0]            blank_cell,
  input  wire logic [tcce_pkg::CELL_W-1:0]            rdata,
  output tcce_pkg::sweep_sts_t                        sts,
  output logic [$clog2(ROWS*COLUMNS)-1:0]             raddr,
  output logic                                        we,
  output logic [$clog2(ROWS*COLUMNS)-1:0]             waddr,
  output logic [tcce_pkg::CELL_W-1:0]                 wdata
);
  import tcce_pkg::*;

  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);
  localparam int AW = $clog2(ROWS*COLUMNS);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
  localparam logic [RW-1:0] LAST_SRC = RW'(ROWS - 2);
  localparam logic [AW-1:0] ROW_STEP = AW'(COLUMNS);

  typedef enum logic [1:0] {S_IDLE, S_COPY, S_FILL, S_DRAIN} state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [AW-1:0]     base_r, base_nxt;
  logic [CW:0]       width_r, width_nxt;
  logic [CELL_W-1:0] const_r, const_nxt;
  // Write stage: the copy data arrives in the cycle after its read.
  logic              wr_vld_r, wr_vld_nxt;
  logic              wr_const_r, wr_const_nxt;
  logic [AW-1:0]     wr_addr_r, wr_addr_nxt;
  logic              row_end;

  assign row_end = ({1'b0, col_r} == width_r - 1'b1);

  always_comb begin
    state_nxt    = state_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    base_nxt     = base_r;
    width_nxt    = width_r;
    const_nxt    = const_r;
    wr_vld_nxt   = 1'b0;
    wr_const_nxt = wr_const_r;
    wr_addr_nxt  = wr_addr_r;
    unique case (state_r)
      S_IDLE: begin
        if (req.start) begin
          col_nxt   = '0;
          row_nxt   = '0;
          base_nxt  = '0;
          width_nxt = act_width;
          const_nxt = req.clear ? CLEAR_WORD : blank_cell;
          state_nxt = req.clear ? S_FILL : S_COPY;
        end
      end
      S_COPY: begin
        wr_vld_nxt   = 1'b1;
        wr_const_nxt = 1'b0;
        wr_addr_nxt  = base_r + AW'(col_r);
        if (row_end) begin
          col_nxt  = '0;
          row_nxt  = row_r + 1'b1;
          base_nxt = base_r + ROW_STEP;
          if (row_r == LAST_SRC) begin
            state_nxt = S_FILL;
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      S_FILL: begin
        wr_vld_nxt   = 1'b1;
        wr_const_nxt = 1'b1;
        wr_addr_nxt  = base_r + AW'(col_r);
        if (row_end) begin
          col_nxt = '0;
          if (row_r == LAST_ROW) begin
            state_nxt = S_DRAIN;
          end else begin
            row_nxt  = row_r + 1'b1;
            base_nxt = base_r + ROW_STEP;
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      wr_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wr_vld_r <= wr_vld_nxt;
    end
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    base_r     <= base_nxt;
    width_r    <= width_nxt;
    const_r    <= const_nxt;
    wr_const_r <= wr_const_nxt;
    wr_addr_r  <= wr_addr_nxt;
  end

  assign raddr     = base_r + ROW_STEP + AW'(col_r);
  assign we        = wr_vld_r;
  assign waddr     = wr_addr_r;
  assign wdata     = wr_const_r ? const_r : rdata;
  assign sts.busy  = (state_r != S_IDLE) || wr_vld_r;
  assign sts.done  = (state_r == S_DRAIN);

endmodule

`default_nettype wire

[sv/tcce_core.sv]
// ----------------------------------------------------------------------------
// Text console core
// Accepts request transactions, keeps the cursor, issues single-cell reads and
// writes, starts scroll and clear sweeps and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  tcce_in_if.sink                            in_ch,
  tcce_out_if.source                         out_ch,
  input  wire logic [$clog2(COLUMNS):0]      act_width,
  input  wire logic [tcce_pkg::CELL_W-1:0]   blank_cell,
  input  wire logic [tcce_pkg::CELL_W-1:0]   rdata,
  input  wire tcce_pkg::sweep_sts_t          sweep_sts,
  output tcce_pkg::sweep_req_t               sweep_req,
  output logic                               we,
  output logic [$clog2(ROWS*COLUMNS)-1:0]    waddr,
  output logic [tcce_pkg::CELL_W-1:0]        wdata,
  output logic [$clog2(ROWS*COLUMNS)-1:0]    raddr
);
  import tcce_pkg::*;

  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int AW    = $clog2(ROWS*COLUMNS);
  localparam int LINW  = (AW > ADDR_IN_W) ? AW : ADDR_IN_W;
  localparam int CMPW  = LINW + 1;
  localparam logic [RW:0]   ROWS_X   = (RW+1)'(ROWS);
  localparam logic [CW:0]   COLS_X   = (CW+1)'(COLUMNS);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

  typedef enum logic [1:0] {C_IDLE, C_READ, C_SWEEP, C_RESULT} state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic [CELL_W-1:0] hold_r, hold_nxt;
  logic              start_r, start_nxt;
  logic              clear_r, clear_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [CELL_W-1:0] dat_r, dat_nxt;

  op_t               op;
  logic              accept;
  logic [CW:0]       c1;
  logic [RW:0]       r1, r2;
  logic              wrap;
  logic [RW-1:0]     tgt_row;
  logic [CW-1:0]     tgt_col;
  logic [LINW-1:0]   addr_ext;
  logic [LINW-1:0]   pos_lin;

  assign op     = op_t'(in_ch.operation);
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == C_IDLE);

  assign addr_ext = LINW'(in_ch.cell_address);
  assign raddr    = addr_ext[AW-1:0];
  assign waddr    = AW'(tgt_row) * AW'(COLUMNS) + AW'(tgt_col);
  assign pos_lin  = LINW'(row_r) * LINW'(COLUMNS) + LINW'(col_r);

  // Put: print or newline first, then the wrap check on the new column.
  always_comb begin
    c1 = {1'b0, col_r};
    r1 = {1'b0, row_r};
    if (in_ch.character == CH_NEWLINE) begin
      c1 = '0;
      r1 = {1'b0, row_r} + 1'b1;
    end else if (in_ch.character != CH_BACKSPACE && in_ch.character != CH_NUL) begin
      c1 = {1'b0, col_r} + 1'b1;
    end
    wrap = (c1 >= act_width);
    r2   = wrap ? r1 + 1'b1 : r1;
  end

  always_comb begin
    tgt_row = row_r;
    tgt_col = col_r;
    wdata   = {in_ch.attribute, in_ch.character};
    we      = 1'b0;
    if (op == OP_DELETE) begin
      wdata = blank_cell;
      if (col_r == '0) begin
        if (row_r != '0) begin
          tgt_row = row_r - 1'b1;
          tgt_col = CW'(act_width - 1'b1);
        end
      end else begin
        tgt_col = col_r - 1'b1;
      end
    end
    if (accept) begin
      if (op == OP_DELETE) begin
        we = 1'b1;
      end else if (op == OP_PUT) begin
        we = (in_ch.character != CH_NEWLINE) && (in_ch.character != CH_BACKSPACE)
          && (in_ch.character != CH_NUL);
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    rd_ok_nxt   = rd_ok_r;
    hold_nxt    = hold_r;
    start_nxt   = 1'b0;
    clear_nxt   = clear_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    pos_nxt     = pos_r;
    dat_nxt     = dat_r;
    unique case (state_r)
      C_IDLE: begin
        if (accept) begin
          hold_nxt  = '0;
          state_nxt = C_RESULT;
          unique case (op)
            OP_PUT: begin
              col_nxt = wrap ? '0 : c1[CW-1:0];
              if (r2 >= ROWS_X) begin
                row_nxt   = LAST_ROW;
                start_nxt = 1'b1;
                clear_nxt = 1'b0;
                state_nxt = C_SWEEP;
              end else begin
                row_nxt = r2[RW-1:0];
              end
            end
            OP_DELETE: begin
              col_nxt = tgt_col;
              row_nxt = tgt_row;
            end
            OP_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = '0;
              start_nxt = 1'b1;
              clear_nxt = 1'b1;
              state_nxt = C_SWEEP;
            end
            OP_READ: begin
              rd_ok_nxt = (CMPW'(in_ch.cell_address) < CMPW'(ROWS*COLUMNS));
              state_nxt = C_READ;
            end
            default: begin
              state_nxt = C_RESULT;
            end
          endcase
        end
      end
      C_READ: begin
        hold_nxt  = rd_ok_r ? rdata : '0;
        state_nxt = C_RESULT;
      end
      C_SWEEP: begin
        if (sweep_sts.done) begin
          state_nxt = C_RESULT;
        end
      end
      C_RESULT: begin
        if (!out_vld_r || out_ch.ready) begin
          out_vld_nxt = 1'b1;
          pos_nxt     = pos_lin[POS_W-1:0];
          dat_nxt     = hold_r;
          state_nxt   = C_IDLE;
        end
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= C_IDLE;
      col_r     <= '0;
      row_r     <= '0;
      start_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      start_r   <= start_nxt;
      out_vld_r <= out_vld_nxt;
    end
    rd_ok_r <= rd_ok_nxt;
    hold_r  <= hold_nxt;
    clear_r <= clear_nxt;
    pos_r   <= pos_nxt;
    dat_r   <= dat_nxt;
  end

  assign sweep_req.start     = start_r;
  assign sweep_req.clear     = clear_r;
  assign out_ch.valid           = out_vld_r;
  assign out_ch.cursor_position = pos_r;
  assign out_ch.cell_data       = dat_r;

  // The cursor always lands inside the screen once a transaction is done.
  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, row_r} < ROWS_X) && ({1'b0, col_r} < COLS_X))
    else $error("cursor outside the screen");

  // A sweep is only started on the way into the sweep wait state.
  a_start_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> (state_r == C_SWEEP))
    else $error("sweep started outside a scroll or clear");

  // Sweep completion is only reported while the core waits for it.
  a_done_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    sweep_sts.done |-> (state_r == C_SWEEP))
    else $error("unexpected sweep completion");

  // Single-cell writes never overlap a running sweep.
  a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> !sweep_sts.busy)
    else $error("cell write during a sweep");

  // Every accepted request reaches the result register before the next one.
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == C_RESULT && state_nxt == C_IDLE) |=> out_vld_r)
    else $error("result not presented");

endmodule

`default_nettype wire

[sv/text_console_cell_engine_top.sv]
// ----------------------------------------------------------------------------
// Text console cell engine
// Teletype over a ROWS x COLUMNS text cell memory with newline, wrap, scroll,
// delete, clear and cell read.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries request transactions (operation, character, attribute,
//   cell_address); out_ch returns one result transaction per request with
//   the cursor position after the request and, for reads, the cell word.
//   cfg_wr_en/cfg_index/cfg_wr_data write full_width (index 0) and
//   blank_cell (index 1); write them only while no request is in flight.
//   Put and delete go from acceptance straight to the result state; a read
//   first passes a read state for the registered memory read. A put that
//   scrolls and a clear also wait in the sweep state while the sweep sequencer
//   walks the active line width of every row, one cell per cycle over the
//   single write port of the cell memory.
//   One request is in progress at a time; the next one is accepted as soon as
//   the previous result is in the output register, even if it is not taken.
//   If the receiver stalls, the finished result is held and the following
//   request waits before its own result is loaded.
//   Reset puts the cursor at the top-left corner and restores the registers;
//   the cell contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cell_engine_top #(
  parameter int COLUMNS       = 80,
  parameter int ROWS          = 25,
  parameter int SPLIT_COLUMNS = 40
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  tcce_in_if.sink                             in_ch,
  tcce_out_if.source                          out_ch,
  input  wire logic                           cfg_wr_en,
  input  wire logic [tcce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tcce_pkg::CELL_W-1:0]    cfg_wr_data
);
  import tcce_pkg::*;

  localparam int CW        = $clog2(COLUMNS);
  localparam int AW        = $clog2(ROWS*COLUMNS);
  localparam int SPLIT_EFF = (SPLIT_COLUMNS < COLUMNS) ? SPLIT_COLUMNS : COLUMNS;

  logic              full_r;
  logic [CELL_W-1:0] blank_r;
  logic [CW:0]       act_width;

  sweep_req_t        sw_req;
  sweep_sts_t        sw_sts;
  logic [AW-1:0]     sw_raddr, sw_waddr, core_raddr, core_waddr;
  logic              sw_we, core_we;
  logic [CELL_W-1:0] sw_wdata, core_wdata;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r  <= 1'b1;
      blank_r <= BLANK_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FULL_WIDTH: full_r  <= cfg_wr_data[0];
        CFG_BLANK_CELL: blank_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  assign act_width = full_r ? (CW+1)'(COLUMNS) : (CW+1)'(SPLIT_EFF);

  // The sweep owns both memory ports while it runs.
  assign mem_we    = sw_sts.busy ? sw_we    : core_we;
  assign mem_waddr = sw_sts.busy ? sw_waddr : core_waddr;
  assign mem_wdata = sw_sts.busy ? sw_wdata : core_wdata;
  assign mem_raddr = sw_sts.busy ? sw_raddr : core_raddr;

  tcce_cell_mem #(
    .DEPTH  (ROWS*COLUMNS),
    .ADDR_W (AW),
    .DATA_W (CELL_W)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata)
  );

  tcce_sweep #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_sweep (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (sw_req),
    .act_width  (act_width),
    .blank_cell (blank_r),
    .rdata      (mem_rdata),
    .sts        (sw_sts),
    .raddr      (sw_raddr),
    .we         (sw_we),
    .waddr      (sw_waddr),
    .wdata      (sw_wdata)
  );

  tcce_core #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .act_width  (act_width),
    .blank_cell (blank_r),
    .rdata      (mem_rdata),
    .sweep_sts  (sw_sts),
    .sweep_req  (sw_req),
    .we         (core_we),
    .waddr      (core_waddr),
    .wdata      (core_wdata),
    .raddr      (core_raddr)
  );

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cell engine testbench
// Drives put, delete, clear and read requests through the request channel,
// first from a short directed table and then in random phases under changing
// line width and blank word settings, and checks every result against a
// fixed result from the table or a predictor of the cell memory and the cursor.
// ----------------------------------------------------------------------------
module testbench;
  import tcce_pkg::*;

  localparam int COLS         = 80;
  localparam int ROWS_N       = 25;
  localparam int SPLIT_W      = 40;
  localparam int HALF_W       = (SPLIT_W < COLS) ? SPLIT_W : COLS;
  localparam int CELL_COUNT   = COLS * ROWS_N;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 140;
  localparam int LIMIT_CYCLES = 8_000_000;

  typedef struct {
    op_t                  op;
    logic [7:0]           ch;
    logic [7:0]           attr;
    logic [ADDR_IN_W-1:0] addr;
  } console_req_t;

  typedef struct {
    logic [POS_W-1:0]  pos;
    logic [CELL_W-1:0] data;
  } console_res_t;

  typedef struct {
    op_t                  op;
    logic [7:0]           ch;
    logic [7:0]           attr;
    logic [ADDR_IN_W-1:0] addr;
    bit                   fixed;
    logic [POS_W-1:0]     pos;
    logic [CELL_W-1:0]    data;
  } console_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CELL_W-1:0]    cfg_wr_data;

  tcce_in_if  in_ch ();
  tcce_out_if out_ch ();

  text_console_cell_engine_top #(
    .COLUMNS       (COLS),
    .ROWS          (ROWS_N),
    .SPLIT_COLUMNS (SPLIT_W)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  always #1 clk = ~clk;

  // Predicted state of the console.
  logic [CELL_W-1:0] screen_model [CELL_COUNT];
  bit                cell_known   [CELL_COUNT];
  int unsigned       cur_row;
  int unsigned       cur_col;
  bit                mode_full;
  logic [CELL_W-1:0] blank_word;

  console_res_t awaited_results [$];
  int           error_count = 0;
  int           cycle_count = 0;
  int           burst_left  = 0;

  // Rows with the fixed flag carry a result that is obvious by inspection.
  console_row_t directed_rows [25] = '{
    '{OP_CLEAR,  8'h00,        8'h00, 11'd0,    1'b1, 11'd0,  16'h0000},
    '{OP_READ,   8'h00,        8'h00, 11'd0,    1'b1, 11'd0,  16'h0F20},
    '{OP_READ,   8'hFF,        8'hFF, 11'd1999, 1'b1, 11'd0,  16'h0F20},
    '{OP_READ,   8'h00,        8'h00, 11'h7FF,  1'b1, 11'd0,  16'h0000},
    '{OP_READ,   8'h00,        8'h00, 11'd2000, 1'b1, 11'd0,  16'h0000},
    '{OP_PUT,    8'h41,        8'hFF, 11'd0,    1'b1, 11'd1,  16'h0000},
    '{OP_READ,   8'h00,        8'h00, 11'd0,    1'b1, 11'd1,  16'hFF41},
    '{OP_PUT,    8'hFF,        8'h00, 11'h7FF,  1'b1, 11'd2,  16'h0000},
    '{OP_PUT,    CH_NUL,       8'hFF, 11'd0,    1'b1, 11'd2,  16'h0000},
    '{OP_PUT,    CH_BACKSPACE, 8'hFF, 11'd0,    1'b1, 11'd2,  16'h0000},
    '{OP_PUT,    8'h7F,        8'h80, 11'd0,    1'b0, 11'd0,  16'h0000},
    '{OP_READ,   8'h00,        8'h00, 11'd2,    1'b0, 11'd0,  16'h0000},
    '{OP_DELETE, 8'hAA,        8'h55, 11'h555,  1'b1, 11'd2,  16'h0000},
    '{OP_READ,   8'h00,        8'h00, 11'd2,    1'b1, 11'd2,  16'h0F20},
    '{OP_DELETE, 8'h00,        8'h00, 11'd0,    1'b1, 11'd1,  16'h0000},
    '{OP_DELETE, 8'h00,        8'h00, 11'd0,    1'b1, 11'd0,  16'h0000},
    '{OP_DELETE, 8'h00,        8'h00, 11'd0,    1'b1, 11'd0,  16'h0000},
    '{OP_READ,   8'h00,        8'h00, 11'd0,    1'b1, 11'd0,  16'h0F20},
    '{OP_PUT,    CH_NEWLINE,   8'h00, 11'd0,    1'b1, 11'd80, 16'h0000},
    '{OP_DELETE, 8'h00,        8'h00, 11'd0,    1'b1, 11'd79, 16'h0000},
    '{OP_READ,   8'h00,        8'h00, 11'd79,   1'b1, 11'd79, 16'h0F20},
    '{OP_PUT,    8'h78,        8'h5A, 11'd0,    1'b0, 11'd0,  16'h0000},
    '{OP_READ,   8'h00,        8'h00, 11'd79,   1'b0, 11'd0,  16'h0000},
    '{OP_PUT,    8'h01,        8'h00, 11'd0,    1'b0, 11'd0,  16'h0000},
    '{OP_CLEAR,  8'hFF,        8'hFF, 11'h7FF,  1'b1, 11'd0,  16'h0000}
  };

  function automatic void reset_console_model();
    for (int i = 0; i < CELL_COUNT; i++) begin
      screen_model[i] = '0;
      cell_known[i]   = 1'b0;
    end
    cur_row    = 0;
    cur_col    = 0;
    mode_full  = 1'b1;
    blank_word = BLANK_RESET;
  endfunction

  function automatic void store_word(int unsigned idx, logic [CELL_W-1:0] word);
    screen_model[idx] = word;
    cell_known[idx]   = 1'b1;
  endfunction

  // Applies one request to the predicted state and returns its result.
  function automatic console_res_t advance_console(console_req_t r);
    console_res_t res;
    int unsigned  w;
    w        = mode_full ? COLS : HALF_W;
    res.data = '0;
    case (r.op)
      OP_PUT: begin
        if (r.ch == CH_NEWLINE) begin
          cur_col = 0;
          cur_row++;
        end else if (r.ch != CH_BACKSPACE && r.ch != CH_NUL) begin
          store_word(cur_row * COLS + cur_col, {r.attr, r.ch});
          cur_col++;
        end
        if (cur_col >= w) begin
          cur_row++;
          cur_col = 0;
        end
        // Scrolling moves only the active columns; the rest keep their words.
        if (cur_row >= ROWS_N) begin
          for (int unsigned i = 0; i < (ROWS_N - 1) * COLS; i++) begin
            if (i % COLS < w) begin
              screen_model[i] = screen_model[i + COLS];
              cell_known[i]   = cell_known[i + COLS];
            end
          end
          for (int unsigned c = 0; c < w; c++)
            store_word((ROWS_N - 1) * COLS + c, blank_word);
          cur_row = ROWS_N - 1;
        end
      end
      OP_DELETE: begin
        if (cur_col == 0) begin
          if (cur_row != 0) begin
            cur_row--;
            cur_col = w - 1;
          end
        end else begin
          cur_col--;
        end
        store_word(cur_row * COLS + cur_col, blank_word);
      end
      OP_CLEAR: begin
        for (int unsigned i = 0; i < CELL_COUNT; i++)
          if (i % COLS < w) store_word(i, CLEAR_WORD);
        cur_row = 0;
        cur_col = 0;
      end
      default: begin
        if (r.addr < CELL_COUNT) res.data = screen_model[r.addr];
      end
    endcase
    res.pos = POS_W'(cur_row * COLS + cur_col);
    return res;
  endfunction

  function automatic console_req_t random_request(int nl_pct);
    console_req_t r;
    int           roll;
    int           pick;
    int unsigned  a;
    r.op   = OP_PUT;
    r.ch   = 8'($urandom);
    r.attr = 8'($urandom);
    r.addr = ADDR_IN_W'($urandom);
    roll   = $urandom_range(0, 99);
    if (roll < 3) begin
      r.ch = roll[0] ? CH_NUL : CH_BACKSPACE;
    end else if (roll < 3 + nl_pct) begin
      r.ch = CH_NEWLINE;
    end else if (roll < 55) begin
      r.op = OP_PUT;
    end else if (roll < 67) begin
      r.op = OP_DELETE;
    end else if (roll < 68) begin
      r.op = OP_CLEAR;
    end else begin
      r.op = OP_READ;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        r.addr = ADDR_IN_W'($urandom_range(CELL_COUNT, 2047));
      end else begin
        a = cur_row * COLS + cur_col;
        if (pick != 1) a = $urandom_range(0, CELL_COUNT - 1);
        else if (a != 0) a = a - 1;
        // Cells never written since reset must not be read.
        if (cell_known[a]) r.addr = ADDR_IN_W'(a);
        else r.addr = ADDR_IN_W'($urandom_range(CELL_COUNT, 2047));
      end
    end
    return r;
  endfunction

  // Inserts a random gap between bursts of back-to-back transactions, none when steady.
  task automatic pace_sender(input bit steady);
    int gap;
    if (burst_left == 0) begin
      gap = steady ? 0 :
            ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  task automatic issue_request(input console_req_t r, input bit fixed,
                               input console_res_t want);
    console_res_t model_res;
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= r.op;
    in_ch.character    <= r.ch;
    in_ch.attribute    <= r.attr;
    in_ch.cell_address <= r.addr;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    model_res = advance_console(r);
    awaited_results.push_back(fixed ? want : model_res);
  endtask

  task automatic settle_console();
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_console_config(input bit full, input logic [CELL_W-1:0] blank);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= CFG_FULL_WIDTH;
    cfg_wr_data <= {15'($urandom), full};
    @(posedge clk);
    cfg_index   <= CFG_BLANK_CELL;
    cfg_wr_data <= blank;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    mode_full  = full;
    blank_word = blank;
  endtask

  initial begin : stimulus
    console_req_t      req;
    console_res_t      want;
    console_res_t      unused;
    bit                full;
    logic [CELL_W-1:0] blank;
    int                nl_pct;
    bit                steady;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.operation    <= OP_PUT;
    in_ch.character    <= '0;
    in_ch.attribute    <= '0;
    in_ch.cell_address <= '0;
    cfg_wr_en          <= 1'b0;
    cfg_index          <= CFG_FULL_WIDTH;
    cfg_wr_data        <= '0;
    unused = '{'0, '0};
    reset_console_model();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      pace_sender(1'b0);
      req  = '{directed_rows[i].op, directed_rows[i].ch, directed_rows[i].attr,
               directed_rows[i].addr};
      want = '{directed_rows[i].pos, directed_rows[i].data};
      issue_request(req, directed_rows[i].fixed, want);
    end

    for (int p = 0; p < PHASES; p++) begin
      full   = (p % 2 == 0);
      blank  = (p == 0) ? 16'h0000 : (p == 1) ? 16'hFFFF : CELL_W'($urandom);
      steady = (p == 2 || p == 5);
      case (p)
        1, 2:    nl_pct = 25;
        4:       nl_pct = 15;
        5:       nl_pct = 20;
        default: nl_pct = 10;
      endcase
      // Leave the cursor in the last column before narrowing the line, so
      // that split mode starts with the cursor beyond its width.
      if (!full) begin
        pace_sender(1'b0);
        issue_request('{OP_PUT, CH_NEWLINE, 8'h07, 11'd0}, 1'b0, unused);
        pace_sender(1'b0);
        issue_request('{OP_DELETE, 8'h00, 8'h00, 11'd0}, 1'b0, unused);
      end
      settle_console();
      write_console_config(full, blank);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pace_sender(steady);
        issue_request(random_request(nl_pct), 1'b0, unused);
      end
    end

    settle_console();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("text_console_cell_engine_top verification clean");
    end else begin
      $display("text_console_cell_engine_top verification failed");
    end
    $finish;
  end

  // The receiver cycles through stall patterns of different character.
  always @(posedge clk) begin : receiver_pace
    case (cycle_count[10:9])
      2'd0:    out_ch.ready <= 1'b1;
      2'd1:    out_ch.ready <= (cycle_count[1:0] != 2'b00);
      2'd2:    out_ch.ready <= cycle_count[2];
      default: out_ch.ready <= ($urandom_range(0, 2) == 0);
    endcase
  end

  always @(posedge clk) begin : result_check
    console_res_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (awaited_results.size() == 0) begin
        $error("result transaction with none expected: cursor_position %0d, cell_data %h",
               out_ch.cursor_position, out_ch.cell_data);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_ch.cursor_position !== want.pos) begin
          $error("cursor_position mismatch: expected %0d, actual %0d",
                 want.pos, out_ch.cursor_position);
          error_count++;
        end
        if (out_ch.cell_data !== want.data) begin
          $error("cell_data mismatch: expected %h, actual %h", want.data, out_ch.cell_data);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("text_console_cell_engine_top verification failed");
      $finish;
    end
  end

endmodule
